// ----- rtl/ctls_pkg.sv -----
// ctls_pkg: shared types, character codes and the byte classifier for the
// token scanner. No dependencies; used by the front, the queue and the back.
package ctls_pkg;

  // character constants
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // token kinds
  localparam logic [3:0] K_UNKNOWN = 4'd0;
  localparam logic [3:0] K_LPAREN  = 4'd1;
  localparam logic [3:0] K_COLON   = 4'd2;
  localparam logic [3:0] K_RPAREN  = 4'd3;
  localparam logic [3:0] K_SEMI    = 4'd4;
  localparam logic [3:0] K_STAR    = 4'd5;
  localparam logic [3:0] K_LBRACK  = 4'd6;
  localparam logic [3:0] K_RBRACK  = 4'd7;
  localparam logic [3:0] K_LBRACE  = 4'd8;
  localparam logic [3:0] K_RBRACE  = 4'd9;
  localparam logic [3:0] K_STRING  = 4'd10;
  localparam logic [3:0] K_IDENT   = 4'd11;
  localparam logic [3:0] K_END     = 4'd12;

  // byte classes
  localparam logic [3:0] CLS_END    = 4'd0;
  localparam logic [3:0] CLS_BLANK  = 4'd1;
  localparam logic [3:0] CLS_EOL    = 4'd2;
  localparam logic [3:0] CLS_SLASH  = 4'd3;
  localparam logic [3:0] CLS_STAR   = 4'd4;
  localparam logic [3:0] CLS_QUOTE  = 4'd5;
  localparam logic [3:0] CLS_BSLASH = 4'd6;
  localparam logic [3:0] CLS_ALPHA  = 4'd7;
  localparam logic [3:0] CLS_IDCONT = 4'd8;
  localparam logic [3:0] CLS_PUNCT  = 4'd9;
  localparam logic [3:0] CLS_OTHER  = 4'd10;

  // queue between front and back
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] cls;
    logic [3:0] kind;
  } ctls_item_t;

  function automatic logic [3:0] punct_kind(input logic [7:0] b);
    logic [3:0] k;
    case (b)
      CH_LPAREN: k = K_LPAREN;
      CH_COLON:  k = K_COLON;
      CH_RPAREN: k = K_RPAREN;
      CH_SEMI:   k = K_SEMI;
      CH_STAR:   k = K_STAR;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic ctls_item_t classify(input logic [7:0] b, input logic last);
    ctls_item_t it;
    logic       alpha;
    logic       digit;
    alpha   = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    digit   = (b >= 8'h30) && (b <= 8'h39);
    it.kind = punct_kind(b);
    if (last || (b == CH_NUL)) begin
      it.cls = CLS_END;
    end else if ((b == CH_SPACE) || (b == CH_TAB)) begin
      it.cls = CLS_BLANK;
    end else if ((b == CH_LF) || (b == CH_CR)) begin
      it.cls = CLS_EOL;
    end else if (b == CH_SLASH) begin
      it.cls = CLS_SLASH;
    end else if (b == CH_STAR) begin
      it.cls = CLS_STAR;
    end else if (b == CH_QUOTE) begin
      it.cls = CLS_QUOTE;
    end else if (b == CH_BSLASH) begin
      it.cls = CLS_BSLASH;
    end else if (alpha) begin
      it.cls = CLS_ALPHA;
    end else if (digit || (b == CH_UNDER)) begin
      it.cls = CLS_IDCONT;
    end else if (it.kind != K_UNKNOWN) begin
      it.cls = CLS_PUNCT;
    end else begin
      it.cls = CLS_OTHER;
    end
    return it;
  endfunction

endpackage

// ----- rtl/ctls_front.sv -----
// ctls_front: accepts text bytes and turns each into a classified item.
// Depends on ctls_pkg; feeds ctls_fifo.
module ctls_front import ctls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       stream_end,
  output logic       push_valid,
  input  logic       push_stall,
  output ctls_item_t push_item
);

  logic seen_end;

  assign push_valid = text_valid;
  assign text_stall = push_stall;
  assign push_item  = classify(text_byte, stream_end);

  // tracks whether the last accepted transaction closed a stream
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_end <= 1'b0;
    end else if (text_valid && !text_stall) begin
      seen_end <= (push_item.cls == CLS_END);
    end
  end

`ifndef SYNTH
  a_end_class: assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_stall && (stream_end || (text_byte == CH_NUL))) |=> seen_end)
    else $error("end of stream not classified as end");
  a_noend_class: assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_stall && !stream_end && (text_byte != CH_NUL)) |=> !seen_end)
    else $error("ordinary byte classified as end");
  a_punct_kind: assert property (@(posedge clk) disable iff (rst)
    (push_valid && (push_item.cls == CLS_PUNCT)) |-> (push_item.kind != K_UNKNOWN))
    else $error("punctuator without kind");
`endif

endmodule

// ----- rtl/ctls_fifo.sv -----
// ctls_fifo: short queue of classified items between front and back.
// Depends on ctls_pkg for the item type and depth.
module ctls_fifo import ctls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_stall,
  input  ctls_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_stall,
  output ctls_item_t pop_item
);

  ctls_item_t           entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_stall = (count == QCNT_BITS'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != QCNT_BITS'(QDEPTH)) |-> (QPTR_BITS'(count) == QPTR_BITS'(wr_ptr - rd_ptr)))
    else $error("queue pointers disagree with count");
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (!do_push && !do_pop) |=> $stable(count))
    else $error("queue count moved without transaction");
`endif

endmodule

// ----- rtl/ctls_back.sv -----
// ctls_back: scanner state machine and token record buffer.
// Depends on ctls_pkg; takes items from ctls_fifo, drives the token channel.
module ctls_back import ctls_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  ctls_item_t             item,
  output logic                   token_valid,
  input  logic                   token_stall,
  output logic [3:0]             token_kind,
  output logic [OFFSET_BITS-1:0] token_start,
  output logic [OFFSET_BITS-1:0] token_length,
  output logic                   overflow_flag,
  output logic                   last_of_run
);

  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_SLASH      = 3'd1;
  localparam logic [2:0] M_LINE       = 3'd2;
  localparam logic [2:0] M_BLOCK      = 3'd3;
  localparam logic [2:0] M_BLOCK_STAR = 3'd4;
  localparam logic [2:0] M_IDENT      = 3'd5;
  localparam logic [2:0] M_STRING     = 3'd6;
  localparam logic [2:0] M_STRING_ESC = 3'd7;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

  localparam int OB_DEPTH = 4;
  localparam int OB_PTR   = $clog2(OB_DEPTH);
  localparam int OB_CNT   = $clog2(OB_DEPTH + 1);

  typedef struct packed {
    logic [3:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] length;
    logic                   ovf;
    logic                   last;
  } rec_t;

  // scanner state
  logic [2:0]             mode;
  logic [OFFSET_BITS-1:0] offset;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [OFFSET_BITS-1:0] tok_len;
  logic                   tok_ovf;
  logic                   sat_seen;

  logic [2:0]             mode_next;
  logic [OFFSET_BITS-1:0] offset_next;
  logic [OFFSET_BITS-1:0] tok_start_next;
  logic [OFFSET_BITS-1:0] tok_len_next;
  logic                   tok_ovf_next;
  logic                   sat_seen_next;

  // record buffer
  rec_t                   obuf [OB_DEPTH];
  logic [OB_PTR-1:0]      ob_wr;
  logic [OB_PTR-1:0]      ob_rd;
  logic [OB_CNT-1:0]      ob_cnt;

  logic                   take;
  logic                   is_end;
  logic                   consumed;
  logic                   grow;
  logic                   has_a;
  logic                   has_b;
  rec_t                   rec_a;
  rec_t                   rec_b;
  rec_t                   rec0;
  logic                   do_pop;
  logic [1:0]             n_rec;

  // room for two records before an item is taken
  assign item_stall = (ob_cnt > OB_CNT'(OB_DEPTH - 2));
  assign take       = item_valid && !item_stall;
  assign is_end     = (item.cls == CLS_END);

  always_comb begin
    mode_next      = mode;
    offset_next    = offset;
    tok_start_next = tok_start;
    tok_len_next   = tok_len;
    tok_ovf_next   = tok_ovf;
    sat_seen_next  = sat_seen;
    consumed       = 1'b0;
    grow           = 1'b0;
    has_a          = 1'b0;
    has_b          = 1'b0;
    rec_a          = '{kind: K_UNKNOWN, start: tok_start, length: tok_len,
                       ovf: tok_ovf, last: 1'b1};
    rec_b          = '{kind: item.kind, start: offset, length: OFF_ONE,
                       ovf: sat_seen, last: 1'b1};

    case (mode)
      M_SLASH: begin
        if (!is_end && (item.cls == CLS_SLASH)) begin
          mode_next = M_LINE;
          consumed  = 1'b1;
        end else if (!is_end && (item.cls == CLS_STAR)) begin
          mode_next = M_BLOCK;
          consumed  = 1'b1;
        end else begin
          has_a        = 1'b1;
          rec_a.length = OFF_ONE;
          mode_next    = M_IDLE;
        end
      end
      M_LINE: begin
        if (is_end || (item.cls == CLS_EOL)) begin
          mode_next = M_IDLE;
        end else begin
          consumed = 1'b1;
        end
      end
      M_BLOCK: begin
        if (is_end) begin
          mode_next = M_IDLE;
        end else begin
          if (item.cls == CLS_STAR) begin
            mode_next = M_BLOCK_STAR;
          end
          consumed = 1'b1;
        end
      end
      M_BLOCK_STAR: begin
        if (is_end) begin
          mode_next = M_IDLE;
        end else begin
          if (item.cls == CLS_SLASH) begin
            mode_next = M_IDLE;
          end else if (item.cls != CLS_STAR) begin
            mode_next = M_BLOCK;
          end
          consumed = 1'b1;
        end
      end
      M_IDENT: begin
        if (!is_end && ((item.cls == CLS_ALPHA) || (item.cls == CLS_IDCONT))) begin
          grow     = 1'b1;
          consumed = 1'b1;
        end else begin
          has_a      = 1'b1;
          rec_a.kind = K_IDENT;
          mode_next  = M_IDLE;
        end
      end
      M_STRING: begin
        if (is_end || (item.cls == CLS_QUOTE)) begin
          has_a      = 1'b1;
          rec_a.kind = K_STRING;
          mode_next  = M_IDLE;
          consumed   = !is_end;
        end else begin
          grow     = 1'b1;
          consumed = 1'b1;
          if (item.cls == CLS_BSLASH) begin
            mode_next = M_STRING_ESC;
          end
        end
      end
      M_STRING_ESC: begin
        if (is_end) begin
          has_a      = 1'b1;
          rec_a.kind = K_STRING;
          mode_next  = M_IDLE;
        end else begin
          grow      = 1'b1;
          mode_next = M_STRING;
          consumed  = 1'b1;
        end
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase

    // saturating length growth
    if (grow) begin
      if (tok_len == OFF_MAX) begin
        tok_ovf_next = 1'b1;
      end else begin
        tok_len_next = tok_len + OFF_ONE;
      end
    end

    if (is_end) begin
      has_b          = 1'b1;
      rec_b.kind     = K_END;
      mode_next      = M_IDLE;
      offset_next    = '0;
      tok_start_next = '0;
      tok_len_next   = '0;
      tok_ovf_next   = 1'b0;
      sat_seen_next  = 1'b0;
    end else begin
      if (!consumed) begin
        case (item.cls)
          CLS_BLANK, CLS_EOL: begin
          end
          CLS_SLASH: begin
            mode_next      = M_SLASH;
            tok_start_next = offset;
            tok_ovf_next   = sat_seen;
          end
          CLS_QUOTE: begin
            mode_next    = M_STRING;
            tok_len_next = '0;
            if (offset == OFF_MAX) begin
              tok_start_next = OFF_MAX;
              tok_ovf_next   = 1'b1;
            end else begin
              tok_start_next = offset + OFF_ONE;
              tok_ovf_next   = sat_seen;
            end
          end
          CLS_ALPHA: begin
            mode_next      = M_IDENT;
            tok_start_next = offset;
            tok_len_next   = OFF_ONE;
            tok_ovf_next   = sat_seen;
          end
          default: begin
            has_b = 1'b1;
          end
        endcase
      end
      if (offset == OFF_MAX) begin
        sat_seen_next = 1'b1;
      end else begin
        offset_next = offset + OFF_ONE;
      end
    end

    if (has_a && has_b) begin
      rec_a.last = 1'b0;
    end
  end

  assign rec0   = has_a ? rec_a : rec_b;
  assign n_rec  = {1'b0, has_a} + {1'b0, has_b};
  assign do_pop = token_valid && !token_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      offset    <= '0;
      tok_start <= '0;
      tok_len   <= '0;
      tok_ovf   <= 1'b0;
      sat_seen  <= 1'b0;
    end else if (take) begin
      mode      <= mode_next;
      offset    <= offset_next;
      tok_start <= tok_start_next;
      tok_len   <= tok_len_next;
      tok_ovf   <= tok_ovf_next;
      sat_seen  <= sat_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (n_rec != 2'd0)) begin
      obuf[ob_wr] <= rec0;
    end
    if (take && (n_rec == 2'd2)) begin
      obuf[ob_wr + OB_PTR'(1)] <= rec_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= '0;
      ob_rd  <= '0;
      ob_cnt <= '0;
    end else begin
      if (take) begin
        ob_wr <= ob_wr + OB_PTR'(n_rec);
      end
      if (do_pop) begin
        ob_rd <= ob_rd + OB_PTR'(1);
      end
      ob_cnt <= ob_cnt + (take ? OB_CNT'(n_rec) : OB_CNT'(0))
                - (do_pop ? OB_CNT'(1) : OB_CNT'(0));
    end
  end

  assign token_valid   = (ob_cnt != '0);
  assign token_kind    = obuf[ob_rd].kind;
  assign token_start   = obuf[ob_rd].start;
  assign token_length  = obuf[ob_rd].length;
  assign overflow_flag = obuf[ob_rd].ovf;
  assign last_of_run   = obuf[ob_rd].last;

`ifndef SYNTH
  a_ob_bound: assert property (@(posedge clk) disable iff (rst)
    ob_cnt <= OB_CNT'(OB_DEPTH))
    else $error("record buffer overrun");
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (take && is_end) |=> ((mode == M_IDLE) && (offset == '0) && !sat_seen))
    else $error("end of stream did not restore scanner state");
  a_sat_pinned: assert property (@(posedge clk) disable iff (rst)
    sat_seen |-> (offset == OFF_MAX))
    else $error("saturation flag set below maximum offset");
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(mode))
    else $error("scan mode moved without a transaction");
`endif

endmodule

// ----- rtl/c_like_token_scanner_unit.sv -----
// channel  | direction | handshake                 | payload
// text     | in        | text_valid / text_stall   | text_byte, stream_end
// token    | out       | token_valid / token_stall | token_kind, token_start,
//          |           |                           | token_length, overflow_flag,
//          |           |                           | last_of_run
// one text byte per cycle while text_stall is low; each item is registered in the queue,
// and its records in the record buffer, before they are offered. a byte that ends an
// identifier or a lone slash and is itself a one-byte token, or that ends a stream inside
// an identifier, string or lone slash, gives two records.
// the back takes a transaction only while its 4-entry record buffer has room for two
// records; when it holds off, the 4-entry queue fills and then text_stall rises.
// c_like_token_scanner_unit: top level of the token scanner.
// Depends on ctls_pkg, ctls_front, ctls_fifo and ctls_back.
module c_like_token_scanner_unit import ctls_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  logic [7:0]             text_byte,
  input  logic                   stream_end,
  output logic                   token_valid,
  input  logic                   token_stall,
  output logic [3:0]             token_kind,
  output logic [OFFSET_BITS-1:0] token_start,
  output logic [OFFSET_BITS-1:0] token_length,
  output logic                   overflow_flag,
  output logic                   last_of_run
);

  logic       push_valid;
  logic       push_stall;
  ctls_item_t push_item;
  logic       head_valid;
  logic       head_stall;
  ctls_item_t head_item;

  ctls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .stream_end (stream_end),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item)
  );

  ctls_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item),
    .pop_valid  (head_valid),
    .pop_stall  (head_stall),
    .pop_item   (head_item)
  );

  ctls_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (head_valid),
    .item_stall    (head_stall),
    .item          (head_item),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_kind    (token_kind),
    .token_start   (token_start),
    .token_length  (token_length),
    .overflow_flag (overflow_flag),
    .last_of_run   (last_of_run)
  );

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for c_like_token_scanner_unit, with an
// in-bench scanner model, directed and random text, and random stalls.
// Depends on ctls_pkg and the scanner RTL.
module tb_top import ctls_pkg::*; ;

  localparam int               OFS_W        = 16;
  localparam logic [OFS_W-1:0] OFS_MAX      = '1;
  localparam int               QUIET_LIMIT  = 2000;
  localparam int               TAIL_CYCLES  = 16;
  localparam int               RANDOM_ITEMS = 1030;
  localparam int               HOLD_CYCLES  = 300;

  typedef enum logic [2:0] {
    SC_IDLE, SC_SLASH, SC_LINE, SC_BLOCK, SC_BLOCK_STAR, SC_IDENT, SC_STRING, SC_STRING_ESC
  } scan_state_t;

  typedef struct {
    logic [3:0]       kind;
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] length;
    logic             ovf;
    logic             is_last;
  } token_rec_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             text_valid;
  logic             text_stall;
  logic [7:0]       text_byte;
  logic             stream_end;
  logic             token_valid;
  logic             token_stall;
  logic [3:0]       token_kind;
  logic [OFS_W-1:0] token_start;
  logic [OFS_W-1:0] token_length;
  logic             overflow_flag;
  logic             last_of_run;

  // scanner model state
  scan_state_t      scan_state;
  logic [OFS_W-1:0] text_offset;
  logic [OFS_W-1:0] open_start;
  logic [OFS_W-1:0] open_len;
  logic             offset_clamped;
  logic             open_flag;

  token_rec_t pending_tokens[$];
  int         mismatch_count = 0;
  int         bytes_sent     = 0;
  int         quiet_cycles   = 0;
  int         hold_req       = 0;
  bit         send_gaps      = 1'b1;
  bit         recv_gaps      = 1'b1;

  c_like_token_scanner_unit #(.OFFSET_BITS(OFS_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .stream_end   (stream_end),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .overflow_flag(overflow_flag),
    .last_of_run  (last_of_run)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic token_rec_t make_rec(input logic [3:0] k, input logic [OFS_W-1:0] s,
                                          input logic [OFS_W-1:0] l, input logic f);
    token_rec_t r;
    r.kind    = k;
    r.start   = s;
    r.length  = l;
    r.ovf     = f;
    r.is_last = 1'b0;
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_word_char(input logic [7:0] b);
    return is_letter(b) || ((b >= "0") && (b <= "9")) || (b == CH_UNDER);
  endfunction

  function automatic logic [3:0] punct_code(input logic [7:0] b);
    case (b)
      CH_LPAREN: return K_LPAREN;
      CH_COLON:  return K_COLON;
      CH_RPAREN: return K_RPAREN;
      CH_SEMI:   return K_SEMI;
      CH_STAR:   return K_STAR;
      CH_LBRACK: return K_LBRACK;
      CH_RBRACK: return K_RBRACK;
      CH_LBRACE: return K_LBRACE;
      CH_RBRACE: return K_RBRACE;
      default:   return K_UNKNOWN;
    endcase
  endfunction

  function automatic void reset_scanner();
    scan_state     = SC_IDLE;
    text_offset    = '0;
    open_start     = '0;
    open_len       = '0;
    offset_clamped = 1'b0;
    open_flag      = 1'b0;
  endfunction

  function automatic void lengthen_token();
    if (open_len == OFS_MAX) begin
      open_flag = 1'b1;
    end else begin
      open_len = open_len + 1'b1;
    end
  endfunction

  // work out the records one accepted byte causes and queue them
  function automatic void predict_tokens(input logic [7:0] b, input logic fin);
    token_rec_t recs[2];
    int         n;
    logic       at_end;
    logic       taken;
    n      = 0;
    at_end = fin || (b == CH_NUL);
    taken  = 1'b0;
    case (scan_state)
      SC_SLASH: begin
        if (!at_end && (b == CH_SLASH)) begin
          scan_state = SC_LINE;
          taken      = 1'b1;
        end else if (!at_end && (b == CH_STAR)) begin
          scan_state = SC_BLOCK;
          taken      = 1'b1;
        end else begin
          recs[n++]  = make_rec(K_UNKNOWN, open_start, OFS_W'(1), open_flag);
          scan_state = SC_IDLE;
        end
      end
      SC_LINE: begin
        if (at_end || (b == CH_LF) || (b == CH_CR)) scan_state = SC_IDLE;
        else taken = 1'b1;
      end
      SC_BLOCK: begin
        if (at_end) begin
          scan_state = SC_IDLE;
        end else begin
          if (b == CH_STAR) scan_state = SC_BLOCK_STAR;
          taken = 1'b1;
        end
      end
      SC_BLOCK_STAR: begin
        if (at_end) begin
          scan_state = SC_IDLE;
        end else begin
          if (b == CH_SLASH) scan_state = SC_IDLE;
          else if (b != CH_STAR) scan_state = SC_BLOCK;
          taken = 1'b1;
        end
      end
      SC_IDENT: begin
        if (!at_end && is_word_char(b)) begin
          lengthen_token();
          taken = 1'b1;
        end else begin
          recs[n++]  = make_rec(K_IDENT, open_start, open_len, open_flag);
          scan_state = SC_IDLE;
        end
      end
      SC_STRING: begin
        if (at_end || (b == CH_QUOTE)) begin
          recs[n++]  = make_rec(K_STRING, open_start, open_len, open_flag);
          scan_state = SC_IDLE;
          taken      = !at_end;
        end else begin
          lengthen_token();
          if (b == CH_BSLASH) scan_state = SC_STRING_ESC;
          taken = 1'b1;
        end
      end
      SC_STRING_ESC: begin
        if (at_end) begin
          recs[n++]  = make_rec(K_STRING, open_start, open_len, open_flag);
          scan_state = SC_IDLE;
        end else begin
          lengthen_token();
          scan_state = SC_STRING;
          taken      = 1'b1;
        end
      end
      default: scan_state = SC_IDLE;
    endcase

    if (at_end) begin
      recs[n++] = make_rec(K_END, text_offset, OFS_W'(1), offset_clamped);
      reset_scanner();
    end else begin
      if (!taken) begin
        if ((b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR)) begin
          // blanks open nothing
        end else if (b == CH_SLASH) begin
          scan_state = SC_SLASH;
          open_start = text_offset;
          open_flag  = offset_clamped;
        end else if (b == CH_QUOTE) begin
          scan_state = SC_STRING;
          open_flag  = offset_clamped;
          open_len   = '0;
          // text starts after the quote, which cannot move past the top offset
          if (text_offset == OFS_MAX) begin
            open_start = OFS_MAX;
            open_flag  = 1'b1;
          end else begin
            open_start = text_offset + 1'b1;
          end
        end else if (is_letter(b)) begin
          scan_state = SC_IDENT;
          open_start = text_offset;
          open_len   = OFS_W'(1);
          open_flag  = offset_clamped;
        end else begin
          recs[n++] = make_rec(punct_code(b), text_offset, OFS_W'(1), offset_clamped);
        end
      end
      if (text_offset == OFS_MAX) offset_clamped = 1'b1;
      else text_offset = text_offset + 1'b1;
    end

    for (int i = 0; i < n; i++) begin
      recs[i].is_last = (i == n - 1);
      pending_tokens.push_back(recs[i]);
    end
  endfunction

  // ------------------------------------------------------- random helpers

  function automatic logic [7:0] random_letter();
    logic [7:0] ofs;
    ofs = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? ("A" + ofs) : ("a" + ofs);
  endfunction

  function automatic logic [7:0] random_word_char();
    logic [7:0] d;
    d = 8'($urandom_range(0, 9));
    case ($urandom_range(0, 3))
      0:       return "0" + d;
      1:       return CH_UNDER;
      default: return random_letter();
    endcase
  endfunction

  function automatic logic [7:0] random_punct();
    case ($urandom_range(0, 8))
      0:       return CH_LPAREN;
      1:       return CH_COLON;
      2:       return CH_RPAREN;
      3:       return CH_SEMI;
      4:       return CH_STAR;
      5:       return CH_LBRACK;
      6:       return CH_RBRACK;
      7:       return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] random_unknown();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0:       b = "0" + 8'($urandom_range(0, 9));
      1:       b = 8'($urandom_range(128, 255));
      default: b = 8'($urandom_range(33, 126));
    endcase
    return b;
  endfunction

  // any nonzero byte other than the quote and the backslash
  function automatic logic [7:0] random_plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while ((b == CH_QUOTE) || (b == CH_BSLASH));
    return b;
  endfunction

  // any nonzero byte that does not end a line
  function automatic logic [7:0] random_comment_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while ((b == CH_LF) || (b == CH_CR));
    return b;
  endfunction

  // ------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = send_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    stream_end <= fin;
    do @(posedge clk); while (text_stall);
    predict_tokens(b, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // stop offering text and wait for every outstanding record
  task automatic finish_phase();
    text_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall before each record, or a long hold on request
  initial begin : token_receiver
    int wait_n;
    token_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        wait_n   = hold_req;
        hold_req = 0;
      end else begin
        wait_n = recv_gaps ? $urandom_range(0, 11) : 0;
      end
      if (wait_n > 0) begin
        token_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      token_stall <= 1'b0;
      do @(posedge clk); while (!(token_valid && !token_stall));
    end
  end

  always @(posedge clk) begin : token_check
    token_rec_t want;
    if (!rst && token_valid && !token_stall) begin
      if (pending_tokens.size() == 0) begin
        $error("token record with none outstanding: kind %0d start %0d", token_kind,
               token_start);
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
          mismatch_count++;
        end
        if (token_start !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, token_start);
          mismatch_count++;
        end
        if (token_length !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, token_length);
          mismatch_count++;
        end
        if (overflow_flag !== want.ovf) begin
          $error("overflow_flag: expected %0d, got %0d", want.ovf, overflow_flag);
          mismatch_count++;
        end
        if (last_of_run !== want.is_last) begin
          $error("last_of_run: expected %0d, got %0d", want.is_last, last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((text_valid && !text_stall) || (token_valid && !token_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_punctuators();
    send_text("(:);*[]{}");
  endtask

  task automatic test_skipped_and_unknown();
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_text("7_");
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_identifiers();
    // the paren both closes the identifier and gives its own record
    send_text("aZ_9(zA ");
  endtask

  task automatic test_strings();
    send_text("\"a\\\"b\"\"\"");
  endtask

  task automatic test_comments();
    send_text("/a//c*\n/**x*/;//");
    send_byte(CH_CR, 1'b0);
  endtask

  task automatic test_stream_end();
    send_text("q");
    send_byte(8'hA5, 1'b1);
    send_text("\"\\");
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_SLASH, 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    send_text("/*");
    send_byte(CH_NUL, 1'b0);
    send_text("\"ab");
    send_byte(CH_NUL, 1'b1);
    send_text("//x");
    send_byte(CH_NUL, 1'b0);
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_req  = HOLD_CYCLES;
    // sender keeps offering while the receiver holds off, so the queues fill
    for (int i = 0; i < 24; i++) begin
      send_byte(random_letter(), 1'b0);
      send_byte(random_punct(), 1'b0);
    end
    finish_phase();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    send_text("x;y(");
    finish_phase();
  endtask

  task automatic test_random_text();
    int target;
    int len;
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 59) == 0) begin
        send_gaps = ($urandom_range(0, 2) != 0);
        recv_gaps = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 9);
          send_byte(random_letter(), 1'b0);
          for (int i = 1; i < len; i++) send_byte(random_word_char(), 1'b0);
        end
        4, 5: begin
          send_byte(CH_QUOTE, 1'b0);
          len = $urandom_range(0, 10);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
              send_byte(CH_BSLASH, 1'b0);
              send_byte(8'($urandom_range(1, 255)), 1'b0);
            end else begin
              send_byte(random_plain_char(), 1'b0);
            end
          end
          if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE, 1'b0);
        end
        6, 7:    send_byte(random_punct(), 1'b0);
        8:       send_byte(random_blank(), 1'b0);
        9: begin
          send_text("//");
          len = $urandom_range(0, 12);
          for (int i = 0; i < len; i++) send_byte(random_comment_char(), 1'b0);
          send_byte($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
        end
        10: begin
          send_text("/*");
          len = $urandom_range(0, 12);
          for (int i = 0; i < len; i++)
            send_byte(($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(1, 255)),
                      1'b0);
          send_text("*/");
        end
        11:      send_byte(CH_SLASH, 1'b0);
        12:      send_byte(random_unknown(), 1'b0);
        13:      send_byte(8'($urandom_range(0, 255)), 1'b0);
        14: begin
          if ($urandom_range(0, 1)) send_byte(CH_NUL, 1'b0);
          else send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        default: send_byte(CH_SPACE, 1'b0);
      endcase
    end
  endtask

  initial begin
    reset_scanner();
    rst        <= 1'b1;
    text_valid <= 1'b0;
    text_byte  <= 8'h00;
    stream_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_punctuators();
    test_skipped_and_unknown();
    test_identifiers();
    test_strings();
    test_comments();
    test_stream_end();
    finish_phase();
    test_backpressure();
    test_random_text();
    finish_phase();

    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
